FILE: rtl/ltok_pkg.sv
// Shared types and constants for the IRC line tokenizer.
// No dependencies; imported by every ltok module.
`default_nettype none
package ltok_pkg;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    PART_SEP    = 3'd0,
    PART_PREFIX = 3'd1,
    PART_CMD    = 3'd2,
    PART_PARAM  = 3'd3,
    PART_TRAIL  = 3'd4
  } part_t;

  typedef enum logic [6:0] {
    PH_START   = 7'b0000001,
    PH_PREFIX  = 7'b0000010,
    PH_PREGAP  = 7'b0000100,
    PH_COMMAND = 7'b0001000,
    PH_GAP     = 7'b0010000,
    PH_PARAM   = 7'b0100000,
    PH_TRAIL   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       line_error;
    logic       line_done;
    logic       param_overflow;
    logic [3:0] param_index;
    logic [7:0] out_char;
    logic       starts_part;
    logic       data_valid;
    part_t      part;
  } res_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'd32;
    return r;
  endfunction

  function automatic logic is_gap(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ltok_core.sv
// Tokenizer state (phase, parameter count) and the per-word tagging logic.
// Depends on ltok_pkg.
`default_nettype none
module ltok_core
  import ltok_pkg::*;
#(
  parameter int MAX_PARAMS = 15
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] ch,
  input  wire logic       line_end,
  output res_t            res
);

  localparam int IdxCapInt = (MAX_PARAMS - 1 < 15) ? MAX_PARAMS - 1 : 15;
  localparam logic [7:0] IdxCap = 8'(IdxCapInt);
  localparam logic [7:0] MaxP   = 8'(MAX_PARAMS);

  phase_t     phase, phase_next;
  logic [7:0] param_count, param_count_next;
  logic       ends, gap;
  logic [7:0] idx;

  assign ends = line_end || (ch == CH_NUL);
  assign gap  = is_gap(ch);

  always_comb begin
    res              = '0;
    res.part         = PART_SEP;
    phase_next       = phase;
    param_count_next = param_count;
    idx              = '0;
    if (ends) begin
      res.line_done    = 1'b1;
      res.line_error   = !(phase == PH_COMMAND || phase == PH_GAP ||
                           phase == PH_PARAM || phase == PH_TRAIL);
      phase_next       = PH_START;
      param_count_next = '0;
    end else begin
      res.out_char = ch;
      unique case (phase)
        PH_PREFIX: begin
          if (gap) phase_next = PH_PREGAP;
          else begin
            res.part       = PART_PREFIX;
            res.data_valid = 1'b1;
          end
        end
        PH_PREGAP: begin
          if (!gap) begin
            res.part        = PART_CMD;
            res.data_valid  = 1'b1;
            res.starts_part = 1'b1;
            res.out_char    = upcase(ch);
            phase_next      = PH_COMMAND;
          end
        end
        PH_COMMAND: begin
          if (gap) phase_next = PH_GAP;
          else begin
            res.part       = PART_CMD;
            res.data_valid = 1'b1;
            res.out_char   = upcase(ch);
          end
        end
        PH_GAP: begin
          if (gap) begin
            res.part = PART_SEP;
          end else if (ch == CH_COLON) begin
            res.part        = PART_TRAIL;
            res.starts_part = 1'b1;
            phase_next      = PH_TRAIL;
          end else begin
            res.part        = PART_PARAM;
            res.data_valid  = 1'b1;
            res.starts_part = 1'b1;
            if (param_count != 8'hFF) param_count_next = param_count + 8'd1;
            phase_next      = PH_PARAM;
          end
        end
        PH_PARAM: begin
          if (gap) phase_next = PH_GAP;
          else begin
            res.part       = PART_PARAM;
            res.data_valid = 1'b1;
          end
        end
        PH_TRAIL: begin
          res.part       = PART_TRAIL;
          res.data_valid = 1'b1;
        end
        default: begin
          // line start
          res.starts_part = 1'b1;
          if (ch == CH_COLON) begin
            res.part   = PART_PREFIX;
            phase_next = PH_PREFIX;
          end else if (gap) begin
            res.part   = PART_CMD;
            phase_next = PH_GAP;
          end else begin
            res.part       = PART_CMD;
            res.data_valid = 1'b1;
            res.out_char   = upcase(ch);
            phase_next     = PH_COMMAND;
          end
        end
      endcase
      if (res.part == PART_PARAM) begin
        // count is at least one once a parameter has begun
        idx                = param_count_next - 8'd1;
        res.param_overflow = (idx >= MaxP);
        res.param_index    = (idx > IdxCap) ? IdxCap[3:0] : idx[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      param_count <= '0;
    end else if (step) begin
      phase       <= phase_next;
      param_count <= param_count_next;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    step && ends |=> phase == PH_START && param_count == 8'd0)
    else $error("phase not back at line start after line end");

  a_count_only_in_line: assert property (@(posedge clk) disable iff (rst)
    phase == PH_START |-> param_count == 8'd0)
    else $error("parameter count nonzero at line start");

  a_ovf_in_param: assert property (@(posedge clk) disable iff (rst)
    res.param_overflow |-> res.part == PART_PARAM && res.param_index == IdxCap[3:0])
    else $error("overflow flagged outside a capped parameter");

endmodule
`default_nettype wire

FILE: rtl/ltok_out_reg.sv
// Result register with stream handshake toward the receiver.
// Depends on ltok_pkg.
`default_nettype none
module ltok_out_reg
  import ltok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire res_t        res,
  output logic             full,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // out_char, param_index, param_overflow, line_error
  output logic [4:0]       m_axis_tuser,  // part, data_valid, starts_part
  output logic             m_axis_tlast   // line_done
);

  res_t hold;
  logic valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) hold <= res;
  end

  assign full          = valid;
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {2'b00, hold.line_error, hold.param_overflow,
                          hold.param_index, hold.out_char};
  assign m_axis_tuser  = {hold.starts_part, hold.data_valid, hold.part};
  assign m_axis_tlast  = hold.line_done;

endmodule
`default_nettype wire

FILE: rtl/irc_line_tokenizer.sv
// Top level of the IRC line tokenizer: input register, tokenizer core, result register.
// Depends on ltok_pkg, ltok_core, ltok_out_reg.
//
// Usage: one character word per transfer on the s_axis side (tdata[7:0] = ch,
// tlast = line_end, which ends the line and carries no character; a zero
// character also ends the line). Every input word gives exactly one result
// word on the m_axis side, in order: tuser carries part, data_valid and
// starts_part; tdata carries out_char, param_index, param_overflow and
// line_error; tlast marks line_done.
// m_axis_tvalid rises once a word has passed the input register and then the
// result register. Throughput is one word per cycle while the receiver does not
// stall, set by the phase update in the core, which is applied when a word moves
// from the input register into the result register.
// When the receiver stalls, the result register holds and the input register
// takes one more word only if it was empty; while it holds a word, s_axis_tready
// stays low until the receiver takes a result.
// Reset (rst, synchronous) empties both registers and returns the tokenizer
// to line start with a zero parameter count.
`default_nettype none
module irc_line_tokenizer
  import ltok_pkg::*;
#(
  parameter int MAX_PARAMS = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // ch
  input  wire logic        s_axis_tlast,   // line_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // out_char, param_index, param_overflow, line_error
  output logic [4:0]       m_axis_tuser,   // part, data_valid, starts_part
  output logic             m_axis_tlast    // line_done
);

  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_end;
  logic       out_full;
  logic       advance;
  res_t       res;

  assign advance       = in_valid && (!out_full || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch  <= s_axis_tdata;
      in_end <= s_axis_tlast;
    end
  end

  ltok_core #(.MAX_PARAMS(MAX_PARAMS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .ch       (in_ch),
    .line_end (in_end),
    .res      (res)
  );

  ltok_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .res           (res),
    .full          (out_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_err_with_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tlast)
    else $error("line_error without line_done");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 5'd0 && m_axis_tdata[12:0] == 13'd0)
    else $error("line end word carries content");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while both registers are full");

endmodule
`default_nettype wire
